>>> hw/rtl/wsd_pkg.sv
package wsd_pkg;

  // Default depth of the queue between the parser and the result stage.
  localparam int unsigned QueueDepth = 2;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  typedef enum logic [2:0] {
    PhByte0 = 3'd0,
    PhByte1 = 3'd1,
    PhLen16 = 3'd2,
    PhLen64 = 3'd3,
    PhKey   = 3'd4,
    PhData  = 3'd5
  } phase_e;

  // One classified item handed from the parser to the result stage.
  typedef struct packed {
    logic        is_header;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic        eof;
  } cmd_t;

endpackage

>>> hw/rtl/wsd_front.sv
module wsd_front import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  phase_e            state_q, state_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              fin_q, fin_d;
  logic [3:0]        op_q, op_d;
  logic              masked_q, masked_d;
  logic [63:0]       len_q, len_d;
  logic [3:0][7:0]   key_q, key_d;
  logic [63:0]       rem_q, rem_d;
  logic [1:0]        kidx_q, kidx_d;

  logic        take;
  logic [6:0]  sz;
  logic [63:0] len_shift;
  logic [63:0] len_val;
  logic        masked_now;
  logic        len_done;
  logic        hdr_done;
  logic        hdr_empty;
  logic        data_last;

  assign in_ready_o = ~q_full_i;
  assign take       = in_valid_i & in_ready_o;
  assign sz         = rx_byte_i[6:0];
  assign len_shift  = {len_q[55:0], rx_byte_i};
  assign data_last  = (rem_q == 64'd1);

  // Classify the current byte: does it end the length field or the header?
  always_comb begin
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    len_val    = len_q;
    masked_now = masked_q;
    unique case (state_q)
      PhByte1: begin
        masked_now = rx_byte_i[7];
        if (sz == Len16Code || sz == Len64Code) begin
          len_val = '0;
        end else begin
          len_val  = 64'(sz);
          len_done = 1'b1;
        end
      end
      PhLen16: begin
        len_val  = len_shift;
        len_done = (cnt_q >= 3'd1);
      end
      PhLen64: begin
        len_val  = len_shift;
        len_done = (cnt_q >= 3'd7);
      end
      PhKey: begin
        hdr_done = (cnt_q >= 3'd3);
      end
      default: ;
    endcase
    if (len_done && !masked_now) begin
      hdr_done = 1'b1;
    end
    hdr_empty = (len_val == 64'd0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    if (take) begin
      unique case (state_q)
        PhByte1, PhLen16, PhLen64, PhKey: begin
          if (hdr_done) begin
            state_d = hdr_empty ? PhByte0 : PhData;
          end else if (len_done) begin
            state_d = PhKey;
          end else if (state_q == PhByte1) begin
            state_d = (sz == Len16Code) ? PhLen16 : PhLen64;
          end
        end
        PhData: begin
          if (data_last) begin
            state_d = PhByte0;
          end
        end
        default: begin
          state_d = PhByte1;
        end
      endcase
    end
  end

  // Header fields, counters and the item pushed to the queue.
  always_comb begin
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    op_d     = op_q;
    masked_d = masked_q;
    len_d    = len_q;
    key_d    = key_q;
    rem_d    = rem_q;
    kidx_d   = kidx_q;
    if (take) begin
      unique case (state_q)
        PhByte1: begin
          masked_d = rx_byte_i[7];
          cnt_d    = 3'd0;
          len_d    = len_val;
        end
        PhLen16, PhLen64: begin
          len_d = len_shift;
          cnt_d = len_done ? 3'd0 : cnt_q + 3'd1;
        end
        PhKey: begin
          key_d = {key_q[2:0], rx_byte_i};
          cnt_d = hdr_done ? 3'd0 : cnt_q + 3'd1;
        end
        PhData: begin
          rem_d  = rem_q - 64'd1;
          kidx_d = kidx_q + 2'd1;
        end
        default: begin
          fin_d = rx_byte_i[7];
          op_d  = rx_byte_i[3:0];
          cnt_d = 3'd0;
        end
      endcase
      if (len_done && masked_now) begin
        key_d = '0;
        cnt_d = 3'd0;
      end
      if (hdr_done) begin
        rem_d  = len_val;
        kidx_d = 2'd0;
        cnt_d  = 3'd0;
      end
    end

    push_o          = take && (hdr_done || state_q == PhData);
    cmd_o.is_header = hdr_done;
    cmd_o.data      = (state_q == PhData) ? rx_byte_i : 8'd0;
    cmd_o.key       = (state_q == PhData && masked_q) ? key_q[2'd3 - kidx_q] : 8'd0;
    cmd_o.fin       = fin_q;
    cmd_o.opcode    = op_q;
    cmd_o.masked    = masked_now;
    cmd_o.length    = hdr_done ? len_val : len_q;
    cmd_o.eof       = hdr_done ? hdr_empty : data_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PhByte0;
      cnt_q   <= 3'd0;
      rem_q   <= 64'd0;
      kidx_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      kidx_q  <= kidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q    <= fin_d;
    op_q     <= op_d;
    masked_q <= masked_d;
    len_q    <= len_d;
    key_q    <= key_d;
  end

`ifndef SYNTHESIS
  a_data_has_bytes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PhData) |-> (rem_q != 64'd0))
    else $error("payload phase entered with no bytes left");
  a_len16_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PhLen16) |-> (cnt_q <= 3'd1))
    else $error("16-bit length count overran");
`endif

endmodule

>>> hw/rtl/wsd_queue.sv
module wsd_queue import wsd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wr_i,
  input  logic pop_i,
  output cmd_t rd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");
`endif

endmodule

>>> hw/rtl/wsd_back.sv
module wsd_back import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        q_cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_header_o,
  output logic [7:0]  payload_byte_o,
  output logic        fin_o,
  output logic [3:0]  frame_opcode_o,
  output logic        masked_o,
  output logic [63:0] payload_length_o,
  output logic [3:0]  message_opcode_o,
  output logic        end_of_frame_o
);

  logic        valid_q;
  logic [3:0]  msg_q, msg_d;
  logic        load;
  cmd_t        res_q;
  logic [7:0]  byte_q;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !q_empty_i;

  // A final header with a non-empty payload sets the message type.
  always_comb begin
    msg_d = msg_q;
    if (pop_o && q_cmd_i.is_header && q_cmd_i.fin && (q_cmd_i.length != 64'd0)) begin
      msg_d = q_cmd_i.opcode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      msg_q   <= 4'd0;
    end else begin
      if (load) begin
        valid_q <= !q_empty_i;
      end
      msg_q <= msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q  <= q_cmd_i;
      byte_q <= q_cmd_i.data ^ q_cmd_i.key;
    end
  end

  assign out_valid_o      = valid_q;
  assign is_header_o      = res_q.is_header;
  assign payload_byte_o   = byte_q;
  assign fin_o            = res_q.fin;
  assign frame_opcode_o   = res_q.opcode;
  assign masked_o         = res_q.masked;
  assign payload_length_o = res_q.length;
  assign message_opcode_o = msg_q;
  assign end_of_frame_o   = res_q.eof;

`ifndef SYNTHESIS
  a_empty_frame_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.is_header && res_q.eof) |-> (res_q.length == 64'd0))
    else $error("frame end on a header of a non-empty frame");
  a_payload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.is_header) |-> (res_q.length != 64'd0))
    else $error("payload byte in a zero-length frame");
`endif

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// Receive-side WebSocket frame deframer.
// The input channel (in_valid_i, in_ready_o, rx_byte_i) takes the received byte
// stream, one byte per item. The output channel (out_valid_o, out_ready_i and
// the result fields) gives one header item when a frame header is complete and
// one item for every payload byte, unmasked with the frame key when the frame
// is masked. end_of_frame_o marks the last item of each frame; an empty frame
// marks its header item. Header bytes other than the last give no item.
// A byte that causes an item is written into the queue and then loaded into
// the output register, where it is seen on the outputs. Throughput: one byte
// per cycle while the queue is not full, set by the header parser; a small
// queue sits between the parser and the output register.
// When the receiver stalls, the output register holds its item and the queue
// fills; in_ready_o drops only while the queue is full, so no item is lost.
// Reset puts the parser at the start of a frame header, empties the queue and
// the output register, and clears the latched message type to zero.
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_header_o,
  output logic [7:0]  payload_byte_o,
  output logic        fin_o,
  output logic [3:0]  frame_opcode_o,
  output logic        masked_o,
  output logic [63:0] payload_length_o,
  output logic [3:0]  message_opcode_o,
  output logic        end_of_frame_o
);

  // Items classified by the parser wait here until the result stage is free.
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  wsd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wr_i    (push_cmd),
    .pop_i   (pop),
    .rd_o    (pop_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The result stage applies the key byte and keeps the message type.
  wsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_cmd_i          (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_header_o      (is_header_o),
    .payload_byte_o   (payload_byte_o),
    .fin_o            (fin_o),
    .frame_opcode_o   (frame_opcode_o),
    .masked_o         (masked_o),
    .payload_length_o (payload_length_o),
    .message_opcode_o (message_opcode_o),
    .end_of_frame_o   (end_of_frame_o)
  );

endmodule

>>> verif/websocket_frame_deframer_test.sv
// Checks the WebSocket deframer against a behavioral model of the frame parser
// kept inside this module. A short list of hand-picked frames comes first, then
// a long run of random frames, and the run ends with a frame whose 64-bit
// length has its top bit set. Each received byte is predicted when the block
// accepts it. Each item taken from the output channel is compared with the
// oldest prediction.
module websocket_frame_deframer_test import wsd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on either channel before the run is declared hung.
  // The longest correct gap is the receiver hold-off.
  localparam int unsigned StallLimit = 3000;
  // Cycles allowed after the last expected item for stray items to show up.
  // This is well above the latency of the block.
  localparam int unsigned DrainCycles = 20;
  // Cycles that the receiver refuses items in one stretch.
  localparam int unsigned HoldOffCycles = 400;

  typedef enum int {
    LenShort,
    LenMid,
    LenLong
  } len_kind_e;

  typedef struct packed {
    logic        is_header;
    logic [7:0]  payload_byte;
    logic        fin;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [3:0]  message_opcode;
    logic        end_of_frame;
  } deframe_result_t;

  // One entry of the sender's queue. A pause entry makes the sender wait
  // until every predicted item has come out of the block.
  typedef struct packed {
    logic       pause;
    logic [7:0] data;
  } rx_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        is_header_o;
  logic [7:0]  payload_byte_o;
  logic        fin_o;
  logic [3:0]  frame_opcode_o;
  logic        masked_o;
  logic [63:0] payload_length_o;
  logic [3:0]  message_opcode_o;
  logic        end_of_frame_o;

  websocket_frame_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_header_o     (is_header_o),
    .payload_byte_o  (payload_byte_o),
    .fin_o           (fin_o),
    .frame_opcode_o  (frame_opcode_o),
    .masked_o        (masked_o),
    .payload_length_o(payload_length_o),
    .message_opcode_o(message_opcode_o),
    .end_of_frame_o  (end_of_frame_o)
  );

  always #10 clk_i = ~clk_i;

  rx_entry_t       rx_stream[$];
  deframe_result_t expected_results[$];
  int unsigned     error_count = 0;
  int unsigned     results_seen = 0;
  int unsigned     quiet_cycles = 0;
  logic            byte_taken = 1'b0;
  logic            calm;

  // Neither side idles at random while this window of the output count is open.
  assign calm = (results_seen >= 600) && (results_seen < 850);

  // Parser state of the model, mirroring the block after reset.
  phase_e      frame_phase = PhByte0;
  logic [2:0]  field_count = '0;
  logic        cur_fin = 1'b0;
  logic [3:0]  cur_opcode = '0;
  logic        cur_masked = 1'b0;
  logic [63:0] cur_length = '0;
  logic [31:0] cur_key = '0;
  logic [63:0] byte_pos = '0;
  logic [3:0]  message_type = '0;

  function automatic void push_result(input logic hdr, input logic [7:0] data,
                                      input logic eof);
    deframe_result_t r;
    r.is_header      = hdr;
    r.payload_byte   = data;
    r.fin            = cur_fin;
    r.frame_opcode   = cur_opcode;
    r.masked         = cur_masked;
    r.payload_length = cur_length;
    r.message_opcode = message_type;
    r.end_of_frame   = eof;
    expected_results = {expected_results, r};
  endfunction

  // The header is complete: latch the message type from a final frame that
  // carries data, then either expect payload or go back to a new header.
  function automatic void finish_header();
    logic empty;
    empty = (cur_length == 64'd0);
    if (cur_fin && !empty) begin
      message_type = cur_opcode;
    end
    byte_pos = '0;
    field_count = '0;
    frame_phase = empty ? PhByte0 : PhData;
    push_result(1'b1, 8'd0, empty);
  endfunction

  // The length is known: a masked frame still has its four key bytes to come.
  function automatic void finish_length();
    if (cur_masked) begin
      frame_phase = PhKey;
      field_count = '0;
      cur_key = '0;
    end else begin
      finish_header();
    end
  endfunction

  // Advances the model by one received byte and queues the item it causes.
  function automatic void decode_rx_byte(input logic [7:0] b);
    logic [1:0] k;
    logic [7:0] key_byte;
    logic       last;
    case (frame_phase)
      PhByte1: begin
        cur_masked = b[7];
        field_count = '0;
        cur_length = '0;
        if (b[6:0] == Len16Code) begin
          frame_phase = PhLen16;
        end else if (b[6:0] == Len64Code) begin
          frame_phase = PhLen64;
        end else begin
          cur_length = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PhLen16: begin
        cur_length = {cur_length[55:0], b};
        if (field_count >= 3'd1) finish_length();
        else field_count = field_count + 3'd1;
      end
      PhLen64: begin
        cur_length = {cur_length[55:0], b};
        if (field_count >= 3'd7) finish_length();
        else field_count = field_count + 3'd1;
      end
      PhKey: begin
        cur_key = {cur_key[23:0], b};
        if (field_count >= 3'd3) finish_header();
        else field_count = field_count + 3'd1;
      end
      PhData: begin
        // Key bytes are applied in arrival order, the first one to payload
        // byte zero of the frame.
        k = byte_pos[1:0];
        key_byte = cur_masked ? cur_key[31 - 8 * k -: 8] : 8'd0;
        last = (byte_pos == cur_length - 64'd1);
        byte_pos = byte_pos + 64'd1;
        if (last) frame_phase = PhByte0;
        push_result(1'b0, b ^ key_byte, last);
      end
      default: begin
        // First header byte; the reserved bits are dropped on purpose.
        cur_fin = b[7];
        cur_opcode = b[3:0];
        field_count = '0;
        frame_phase = PhByte1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void append_entry(input logic pause, input logic [7:0] b);
    rx_entry_t e;
    e.pause = pause;
    e.data = b;
    rx_stream = {rx_stream, e};
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    append_entry(1'b0, b);
  endfunction

  // Queues one whole frame: header, extended length, key and payload bytes.
  // The number of payload bytes sent may be less than the length announced.
  function automatic void queue_frame(input logic fin, input logic [2:0] rsv,
                                      input logic [3:0] opcode, input logic masked,
                                      input len_kind_e kind, input logic [63:0] length,
                                      input logic [31:0] key, input int unsigned send_count);
    push_byte({fin, rsv, opcode});
    case (kind)
      LenShort: push_byte({masked, length[6:0]});
      LenMid: begin
        push_byte({masked, Len16Code});
        push_byte(length[15:8]);
        push_byte(length[7:0]);
      end
      default: begin
        push_byte({masked, Len64Code});
        for (int i = 7; i >= 0; i--) push_byte(length[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
    end
    for (int unsigned i = 0; i < send_count; i++) push_byte(8'($urandom_range(255)));
  endfunction

  // Output check, prediction and hang detection, all on the rising edge. The
  // output is checked before the byte taken on the same edge is predicted;
  // that byte must pass the queue and the output register before it shows up.
  always @(posedge clk_i) begin : edge_monitor
    deframe_result_t oldest;
    logic            result_taken;
    if (rst_ni) begin
      result_taken = out_valid_o && out_ready_i;
      if (result_taken) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no prediction waiting");
          error_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("is_header", 64'(oldest.is_header), 64'(is_header_o));
          check_field("payload_byte", 64'(oldest.payload_byte), 64'(payload_byte_o));
          check_field("fin", 64'(oldest.fin), 64'(fin_o));
          check_field("frame_opcode", 64'(oldest.frame_opcode), 64'(frame_opcode_o));
          check_field("masked", 64'(oldest.masked), 64'(masked_o));
          check_field("payload_length", oldest.payload_length, payload_length_o);
          check_field("message_opcode", 64'(oldest.message_opcode),
                      64'(message_opcode_o));
          check_field("end_of_frame", 64'(oldest.end_of_frame), 64'(end_of_frame_o));
        end
      end
      byte_taken = in_valid_i && in_ready_o;
      if (byte_taken) decode_rx_byte(rx_byte_i);
      quiet_cycles = (byte_taken || result_taken) ? 0 : quiet_cycles + 1;
    end
  end

  // Sender. A new byte is offered only once the previous one was taken, so
  // valid and data hold steady through any stall. Each side of the handshake
  // is assigned once per falling edge.
  always @(negedge clk_i) begin : byte_driver
    rx_entry_t  head;
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = in_valid_i;
    next_byte = rx_byte_i;
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      next_valid = 1'b0;
      // A pause entry holds the stream until the block has drained.
      if (rx_stream.size() > 0 && rx_stream[0].pause && expected_results.size() == 0) begin
        void'(rx_stream.pop_front());
      end
      if (rx_stream.size() > 0 && !rx_stream[0].pause &&
          (calm || $urandom_range(99) >= 17)) begin
        head = rx_stream.pop_front();
        next_valid = 1'b1;
        next_byte = head.data;
      end
    end
    in_valid_i <= next_valid;
    rx_byte_i <= next_byte;
  end

  // Receiver. Once some hundreds of items have passed it refuses everything
  // for a long stretch, so the internal queue fills and the input stalls
  // while the sender keeps offering bytes.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin : result_sink
    logic next_ready;
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
      next_ready = 1'b0;
    end else begin
      next_ready = calm || ($urandom_range(99) >= 17);
    end
    out_ready_i <= next_ready;
  end

  initial begin : hang_watch
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned frame_count;
    logic [3:0]  opcode;
    logic        masked;
    len_kind_e   kind;
    logic [63:0] length;
    int unsigned pick;

    // Directed frames. An empty final frame with all reserved bits set: its
    // header item ends the frame and the message type stays untouched.
    queue_frame(1'b1, 3'b111, 4'h1, 1'b0, LenShort, 64'd0, 32'h0, 0);
    // A non-final frame with a reserved opcode, unmasked.
    queue_frame(1'b0, 3'b000, 4'hB, 1'b0, LenShort, 64'd1, 32'h0, 1);
    // A masked final frame; the key mixes all-ones and all-zeros bytes.
    queue_frame(1'b1, 3'b000, 4'h2, 1'b1, LenShort, 64'd2, 32'hFF00_A55A, 2);
    // A 16-bit length that would have fit in seven bits.
    queue_frame(1'b1, 3'b000, 4'hF, 1'b0, LenMid, 64'd1, 32'h0, 1);
    // A control opcode with a 64-bit length of zero.
    queue_frame(1'b1, 3'b000, 4'h9, 1'b0, LenLong, 64'd0, 32'h0, 0);

    // Random frames, mostly well-formed with common opcodes and short
    // payloads, with now and then a drain of the whole block.
    frame_count = 0;
    while (rx_stream.size() < 1360) begin
      if (frame_count % 25 == 24) append_entry(1'b1, 8'd0);
      frame_count++;
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(5))
          0: opcode = 4'h0;
          1: opcode = 4'h1;
          2: opcode = 4'h2;
          3: opcode = 4'h8;
          4: opcode = 4'h9;
          default: opcode = 4'hA;
        endcase
      end else begin
        opcode = 4'($urandom_range(15));
      end
      masked = ($urandom_range(99) < 70);
      pick = $urandom_range(99);
      if (pick < 75) begin
        kind = LenShort;
        length = ($urandom_range(99) < 85) ? 64'($urandom_range(20))
                                           : 64'($urandom_range(125));
      end else if (pick < 92) begin
        kind = LenMid;
        length = ($urandom_range(99) < 90) ? 64'($urandom_range(40))
                                           : 64'($urandom_range(300));
      end else begin
        kind = LenLong;
        length = 64'($urandom_range(40));
      end
      queue_frame(1'($urandom_range(1)), 3'($urandom_range(7)), opcode, masked, kind,
                  length, $urandom(), 32'(length));
    end

    // Last, a frame with a 64-bit length whose top bit is set. It can never
    // finish, so only a few of its payload bytes are sent.
    length = {1'b1, 31'($urandom()), 32'($urandom())};
    queue_frame(1'b1, 3'b000, 4'h2, 1'b1, LenLong, length, $urandom(), 24);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (rx_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer.sv
verif/websocket_frame_deframer_test.sv
